// ----- sv/llhp_pkg.sv -----
// ----------------------------------------------------------------------------
// LOAS/LATM header parser package
// Parse phases, rate table and shared types.
// ----------------------------------------------------------------------------
package llhp_pkg;

   typedef enum logic [5:0] {
      P_IDLE, P_SYNC, P_LEN, P_SAME_MUX, P_VER, P_VER_A, P_TARA_N, P_TARA_B,
      P_FRAMING, P_SUBFR, P_NPROG, P_NLAYER, P_ASCLEN_N, P_ASCLEN_B,
      P_AOT, P_AOT_EXT, P_SFI, P_RATE, P_CHAN, P_XSFI, P_XRATE, P_AOT2,
      P_AOT2_EXT, P_GA_FLEN, P_GA_DEP, P_GA_DELAY, P_GA_EXT, P_GA_LAYNR,
      P_GA_E22, P_GA_E3, P_GA_E1,
      P_FILL, P_FLT, P_FULL, P_FLEN9, P_CELP, P_HVXC, P_OD_FLAG, P_OD_N,
      P_OD_B, P_OD_ESC, P_OD_BYTE, P_CRC_FLAG, P_CRC, P_PL_CHUNK, P_PL_STREAM,
      P_PL_BYTE, P_PL_CODED, P_PL_AUEND, P_DONE
   } phase_type;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_BAD_SYNC = 3'd1;
   localparam logic [2:0] ST_VER_A    = 3'd2;
   localparam logic [2:0] ST_PROGS    = 3'd3;
   localparam logic [2:0] ST_LAYERS   = 3'd4;

   localparam logic [10:0] SYNC_WORD = 11'h2b7;
   localparam logic [12:0] SLOT_MAX  = 13'd8191;

   function automatic logic [23:0] rate_lookup(input logic [3:0] idx);
      logic [23:0] r;
      begin
         case (idx)
            4'd0:  r = 24'd96000;
            4'd1:  r = 24'd88200;
            4'd2:  r = 24'd64000;
            4'd3:  r = 24'd48000;
            4'd4:  r = 24'd44100;
            4'd5:  r = 24'd32000;
            4'd6:  r = 24'd24000;
            4'd7:  r = 24'd22050;
            4'd8:  r = 24'd16000;
            4'd9:  r = 24'd12000;
            4'd10: r = 24'd11025;
            4'd11: r = 24'd8000;
            4'd12: r = 24'd7350;
            default: r = 24'd0;
         endcase
         return r;
      end
   endfunction

   function automatic logic is_ga(input logic [6:0] t);
      return (t >= 7'd1 && t <= 7'd4) || t == 7'd6 || t == 7'd7 || t == 7'd17 ||
             (t >= 7'd19 && t <= 7'd23);
   endfunction

endpackage

// ----- sv/loas_latm_header_parser_unit.sv -----
// ----------------------------------------------------------------------------
// LOAS/LATM header parser unit
// Bit-serial AudioSyncStream / StreamMuxConfig parser, one result per frame.
// ----------------------------------------------------------------------------
// Each byte is loaded into the field shifter and then shifted one bit per
// cycle; the result appears the cycle after the bit that completes the
// header. A new byte is taken only once the single-bit field shifter is
// done with the last one and no stalled result is pending. Reset clears the
// sequencer, saved config and last_parse_ok; the parser waits for frame_start.
module loas_latm_header_parser_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_frame_start,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [12:0] rsp_mux_length,
   output logic        rsp_config_reused,
   output logic [6:0]  rsp_object_type,
   output logic [23:0] rsp_sample_rate,
   output logic [3:0]  rsp_channel_config,
   output logic [2:0]  rsp_frame_length_kind,
   output logic [7:0]  rsp_buffer_fullness,
   output logic [5:0]  rsp_subframe_count,
   output logic [12:0] rsp_slot_length,
   output logic [31:0] rsp_other_data_length,
   output logic [31:0] rsp_audio_config_word
);

   llhp_pkg::phase_type phase_ff, phase_in;
   logic        busy_ff, busy_in;
   logic [7:0]  shift_ff, shift_in;
   logic [2:0]  bcnt_ff, bcnt_in;
   logic [31:0] acc_ff, acc_in;
   logic [5:0]  left_ff, left_in;
   logic [31:0] fill_ff, fill_in;
   logic        lastok_ff, lastok_in;
   logic [63:0] sv0_ff, sv0_in, sv1_ff, sv1_in;
   logic        samefr_ff, samefr_in;
   logic        cver_ff, cver_in, cfr_ff, cfr_in, creu_ff, creu_in;
   logic        cgaext_ff, cgaext_in, esc_ff, esc_in, cap_ff, cap_in;
   logic [12:0] clen_ff, clen_in, cslot_ff, cslot_in;
   logic [5:0]  csub_ff, csub_in;
   logic [6:0]  caot_ff, caot_in;
   logic [23:0] crate_ff, crate_in;
   logic [3:0]  cchan_ff, cchan_in;
   logic [2:0]  cflt_ff, cflt_in;
   logic [7:0]  cfull_ff, cfull_in;
   logic [31:0] codl_ff, codl_in, aword_ff, aword_in, abits_ff, abits_in;
   logic [31:0] alen_ff, alen_in;
   logic [5:0]  awbits_ff, awbits_in;
   logic [2:0]  bleft_ff, bleft_in;
   logic        ov_ff, ov_in;
   logic [2:0]  ost_ff, ost_in;
   logic [12:0] olen_ff, olen_in, oslot_ff, oslot_in;
   logic        oreu_ff, oreu_in;
   logic [63:0] ow0_ff, ow0_in, ow1_ff, ow1_in;

   logic        b;
   logic [31:0] v;
   logic [13:0] slot_sum;
   logic [31:0] word;

   assign req_stall = busy_ff || (ov_ff && rsp_stall);
   assign rsp_valid = ov_ff;
   assign rsp_status = ost_ff;
   assign rsp_mux_length = olen_ff;
   assign rsp_config_reused = oreu_ff;
   assign rsp_object_type = ow0_ff[6:0];
   assign rsp_channel_config = ow0_ff[10:7];
   assign rsp_frame_length_kind = ow0_ff[13:11];
   assign rsp_buffer_fullness = ow0_ff[21:14];
   assign rsp_subframe_count = ow0_ff[27:22];
   assign rsp_sample_rate = ow0_ff[51:28];
   assign rsp_slot_length = oslot_ff;
   assign rsp_other_data_length = ow1_ff[31:0];
   assign rsp_audio_config_word = ow1_ff[63:32];

   always_comb begin
      phase_in = phase_ff; busy_in = busy_ff; shift_in = shift_ff; bcnt_in = bcnt_ff;
      acc_in = acc_ff; left_in = left_ff; fill_in = fill_ff; lastok_in = lastok_ff;
      sv0_in = sv0_ff; sv1_in = sv1_ff; samefr_in = samefr_ff;
      cver_in = cver_ff; cfr_in = cfr_ff; creu_in = creu_ff; cgaext_in = cgaext_ff;
      esc_in = esc_ff; cap_in = cap_ff; clen_in = clen_ff; cslot_in = cslot_ff;
      csub_in = csub_ff; caot_in = caot_ff; crate_in = crate_ff; cchan_in = cchan_ff;
      cflt_in = cflt_ff; cfull_in = cfull_ff; codl_in = codl_ff; aword_in = aword_ff;
      abits_in = abits_ff; alen_in = alen_ff; awbits_in = awbits_ff; bleft_in = bleft_ff;
      ov_in = ov_ff && rsp_stall; ost_in = ost_ff; olen_in = olen_ff; oslot_in = oslot_ff;
      oreu_in = oreu_ff; ow0_in = ow0_ff; ow1_in = ow1_ff;
      b = shift_ff[7];
      v = {acc_ff[30:0], b};
      slot_sum = {1'b0, cslot_ff} + {6'd0, v[7:0]};
      word = 32'd0;

      if (req_valid && !req_stall) begin
         if (req_frame_start) begin
            cver_in = 1'b0; cfr_in = 1'b0; clen_in = '0; csub_in = '0; caot_in = '0;
            crate_in = '0; cchan_in = '0; cflt_in = '0; cfull_in = '0; codl_in = '0;
            cslot_in = '0; creu_in = 1'b0; cgaext_in = 1'b0; esc_in = 1'b0;
            bleft_in = '0; aword_in = '0; awbits_in = '0; abits_in = '0; alen_in = '0;
            cap_in = 1'b0; fill_in = '0;
            phase_in = llhp_pkg::P_SYNC; acc_in = '0; left_in = 6'd11;
         end
         shift_in = req_data_byte;
         bcnt_in = '0;
         busy_in = !(phase_in == llhp_pkg::P_IDLE || phase_in == llhp_pkg::P_DONE);
      end else if (busy_ff) begin
         shift_in = {shift_ff[6:0], 1'b0};
         bcnt_in = bcnt_ff + 3'd1;
         if (cap_ff && awbits_ff < 6'd32) begin
            aword_in = {aword_ff[30:0], b};
            awbits_in = awbits_ff + 6'd1;
         end
         if (phase_ff >= llhp_pkg::P_AOT && phase_ff <= llhp_pkg::P_GA_E1)
            abits_in = abits_ff + 32'd1;
         if (phase_ff == llhp_pkg::P_FILL) begin
            fill_in = fill_ff - 32'd1;
            if (fill_ff == 32'd1) begin
               phase_in = llhp_pkg::P_FLT; acc_in = '0; left_in = 6'd3;
            end
         end else begin
            acc_in = v;
            left_in = (left_ff > 6'd0) ? left_ff - 6'd1 : 6'd0;
            if (left_in == 6'd0) begin
               handle_field();
            end
         end
         if (bcnt_ff == 3'd7 || phase_in == llhp_pkg::P_IDLE ||
             phase_in == llhp_pkg::P_DONE)
            busy_in = 1'b0;
      end
   end

   function automatic void want(input llhp_pkg::phase_type p, input logic [5:0] n);
      phase_in = p; acc_in = '0; left_in = n;
   endfunction

   function automatic void emit(input logic [2:0] st);
      ov_in = 1'b1; ost_in = st; olen_in = clen_in;
      oreu_in = 1'b0; oslot_in = '0; ow0_in = '0; ow1_in = '0;
      if (st == llhp_pkg::ST_OK) begin
         oreu_in = creu_in; oslot_in = cslot_in; ow0_in = sv0_in; ow1_in = sv1_in;
      end
      phase_in = llhp_pkg::P_DONE;
   endfunction

   function automatic void fail(input logic [2:0] st);
      lastok_in = 1'b0;
      emit(st);
   endfunction

   function automatic void pl_stream();
      logic [2:0] f;
      f = sv0_in[13:11];
      if (f == 3'd0) begin
         cslot_in = '0; want(llhp_pkg::P_PL_BYTE, 6'd8);
      end else if (f == 3'd3 || f == 3'd5 || f == 3'd7) begin
         want(llhp_pkg::P_PL_CODED, 6'd2);
      end else begin
         emit(llhp_pkg::ST_OK);
      end
   endfunction

   function automatic void start_payload();
      if (!samefr_in) want(llhp_pkg::P_PL_CHUNK, 6'd4);
      else pl_stream();
   endfunction

   function automatic void commit();
      logic [31:0] w;
      w = '0;
      if (awbits_in >= 6'd32) w = aword_in;
      else if (awbits_in > 6'd0) w = aword_in << (6'd32 - awbits_in);
      sv0_in = {12'd0, crate_in, csub_in, cfull_in, cflt_in, cchan_in, caot_in};
      sv1_in = {w, codl_in};
      samefr_in = cfr_in;
      lastok_in = 1'b1;
      cap_in = 1'b0;
      start_payload();
   endfunction

   function automatic void start_asc();
      cap_in = 1'b1; aword_in = '0; awbits_in = '0; abits_in = '0;
      want(llhp_pkg::P_AOT, 6'd5);
   endfunction

   function automatic void asc_done();
      if (cver_in && alen_in > abits_in) begin
         fill_in = alen_in - abits_in; phase_in = llhp_pkg::P_FILL;
      end else begin
         want(llhp_pkg::P_FLT, 6'd3);
      end
   endfunction

   function automatic void after_aot2();
      if (llhp_pkg::is_ga(caot_in)) want(llhp_pkg::P_GA_FLEN, 6'd1);
      else asc_done();
   endfunction

   function automatic void ga_e3();
      if (caot_in == 7'd17 || caot_in == 7'd19 || caot_in == 7'd20 || caot_in == 7'd23)
         want(llhp_pkg::P_GA_E3, 6'd3);
      else
         want(llhp_pkg::P_GA_E1, 6'd1);
   endfunction

   function automatic void ga_ext_part();
      if (!cgaext_in) asc_done();
      else if (caot_in == 7'd22) want(llhp_pkg::P_GA_E22, 6'd16);
      else ga_e3();
   endfunction

   function automatic void handle_field();
      case (phase_ff)
         llhp_pkg::P_SYNC: begin
            if (v[10:0] != llhp_pkg::SYNC_WORD || v[31:11] != '0) emit(llhp_pkg::ST_BAD_SYNC);
            else want(llhp_pkg::P_LEN, 6'd13);
         end
         llhp_pkg::P_LEN: begin
            clen_in = v[12:0]; want(llhp_pkg::P_SAME_MUX, 6'd1);
         end
         llhp_pkg::P_SAME_MUX: begin
            if (v[0] && lastok_ff) begin
               creu_in = 1'b1; start_payload();
            end else want(llhp_pkg::P_VER, 6'd1);
         end
         llhp_pkg::P_VER: begin
            cver_in = v[0];
            want(v[0] ? llhp_pkg::P_VER_A : llhp_pkg::P_FRAMING, 6'd1);
         end
         llhp_pkg::P_VER_A: begin
            if (v[0]) fail(llhp_pkg::ST_VER_A);
            else want(llhp_pkg::P_TARA_N, 6'd2);
         end
         llhp_pkg::P_TARA_N: begin
            bleft_in = {1'b0, v[1:0]} + 3'd1; want(llhp_pkg::P_TARA_B, 6'd8);
         end
         llhp_pkg::P_TARA_B: begin
            bleft_in = bleft_ff - 3'd1;
            if (bleft_in != 3'd0) want(llhp_pkg::P_TARA_B, 6'd8);
            else want(llhp_pkg::P_FRAMING, 6'd1);
         end
         llhp_pkg::P_FRAMING: begin
            cfr_in = v[0]; want(llhp_pkg::P_SUBFR, 6'd6);
         end
         llhp_pkg::P_SUBFR: begin
            csub_in = v[5:0]; want(llhp_pkg::P_NPROG, 6'd4);
         end
         llhp_pkg::P_NPROG: begin
            if (v[3:0] != 4'd0) fail(llhp_pkg::ST_PROGS);
            else want(llhp_pkg::P_NLAYER, 6'd3);
         end
         llhp_pkg::P_NLAYER: begin
            if (v[2:0] != 3'd0) fail(llhp_pkg::ST_LAYERS);
            else if (cver_ff) want(llhp_pkg::P_ASCLEN_N, 6'd2);
            else start_asc();
         end
         llhp_pkg::P_ASCLEN_N: begin
            bleft_in = {1'b0, v[1:0]} + 3'd1; alen_in = '0;
            want(llhp_pkg::P_ASCLEN_B, 6'd8);
         end
         llhp_pkg::P_ASCLEN_B: begin
            alen_in = {alen_ff[23:0], v[7:0]};
            bleft_in = bleft_ff - 3'd1;
            if (bleft_in != 3'd0) want(llhp_pkg::P_ASCLEN_B, 6'd8);
            else start_asc();
         end
         llhp_pkg::P_AOT: begin
            if (v[4:0] == 5'd31) want(llhp_pkg::P_AOT_EXT, 6'd6);
            else begin
               caot_in = {2'd0, v[4:0]}; want(llhp_pkg::P_SFI, 6'd4);
            end
         end
         llhp_pkg::P_AOT_EXT: begin
            caot_in = 7'd32 + {1'b0, v[5:0]}; want(llhp_pkg::P_SFI, 6'd4);
         end
         llhp_pkg::P_SFI: begin
            crate_in = llhp_pkg::rate_lookup(v[3:0]);
            if (v[3:0] == 4'd15) want(llhp_pkg::P_RATE, 6'd24);
            else want(llhp_pkg::P_CHAN, 6'd4);
         end
         llhp_pkg::P_RATE: begin
            crate_in = v[23:0]; want(llhp_pkg::P_CHAN, 6'd4);
         end
         llhp_pkg::P_CHAN: begin
            cchan_in = v[3:0];
            if (caot_ff == 7'd5) want(llhp_pkg::P_XSFI, 6'd4);
            else after_aot2();
         end
         llhp_pkg::P_XSFI: begin
            if (v[3:0] == 4'd15) want(llhp_pkg::P_XRATE, 6'd24);
            else want(llhp_pkg::P_AOT2, 6'd5);
         end
         llhp_pkg::P_XRATE: begin
            crate_in = v[23:0]; want(llhp_pkg::P_AOT2, 6'd5);
         end
         llhp_pkg::P_AOT2: begin
            if (v[4:0] == 5'd31) want(llhp_pkg::P_AOT2_EXT, 6'd6);
            else begin
               caot_in = {2'd0, v[4:0]}; after_aot2();
            end
         end
         llhp_pkg::P_AOT2_EXT: begin
            caot_in = 7'd32 + {1'b0, v[5:0]}; after_aot2();
         end
         llhp_pkg::P_GA_FLEN: want(llhp_pkg::P_GA_DEP, 6'd1);
         llhp_pkg::P_GA_DEP: begin
            if (v[0]) want(llhp_pkg::P_GA_DELAY, 6'd14);
            else want(llhp_pkg::P_GA_EXT, 6'd1);
         end
         llhp_pkg::P_GA_DELAY: want(llhp_pkg::P_GA_EXT, 6'd1);
         llhp_pkg::P_GA_EXT: begin
            cgaext_in = v[0];
            if (caot_ff == 7'd6 || caot_ff == 7'd20) want(llhp_pkg::P_GA_LAYNR, 6'd3);
            else ga_ext_part();
         end
         llhp_pkg::P_GA_LAYNR: ga_ext_part();
         llhp_pkg::P_GA_E22: ga_e3();
         llhp_pkg::P_GA_E3: want(llhp_pkg::P_GA_E1, 6'd1);
         llhp_pkg::P_GA_E1: asc_done();
         llhp_pkg::P_FLT: begin
            cflt_in = v[2:0];
            if (v[2:0] == 3'd0) want(llhp_pkg::P_FULL, 6'd8);
            else if (v[2:0] == 3'd1) want(llhp_pkg::P_FLEN9, 6'd9);
            else if (v[2:0] >= 3'd3 && v[2:0] <= 3'd5) want(llhp_pkg::P_CELP, 6'd6);
            else if (v[2:0] >= 3'd6) want(llhp_pkg::P_HVXC, 6'd1);
            else want(llhp_pkg::P_OD_FLAG, 6'd1);
         end
         llhp_pkg::P_FULL: begin
            cfull_in = v[7:0]; want(llhp_pkg::P_OD_FLAG, 6'd1);
         end
         llhp_pkg::P_FLEN9, llhp_pkg::P_CELP, llhp_pkg::P_HVXC:
            want(llhp_pkg::P_OD_FLAG, 6'd1);
         llhp_pkg::P_OD_FLAG: begin
            codl_in = '0;
            if (!v[0]) want(llhp_pkg::P_CRC_FLAG, 6'd1);
            else if (cver_ff) want(llhp_pkg::P_OD_N, 6'd2);
            else want(llhp_pkg::P_OD_ESC, 6'd1);
         end
         llhp_pkg::P_OD_N: begin
            bleft_in = {1'b0, v[1:0]} + 3'd1; want(llhp_pkg::P_OD_B, 6'd8);
         end
         llhp_pkg::P_OD_B: begin
            codl_in = {codl_ff[23:0], v[7:0]};
            bleft_in = bleft_ff - 3'd1;
            if (bleft_in != 3'd0) want(llhp_pkg::P_OD_B, 6'd8);
            else want(llhp_pkg::P_CRC_FLAG, 6'd1);
         end
         llhp_pkg::P_OD_ESC: begin
            esc_in = v[0]; want(llhp_pkg::P_OD_BYTE, 6'd8);
         end
         llhp_pkg::P_OD_BYTE: begin
            codl_in = {codl_ff[23:0], v[7:0]};
            if (esc_ff) want(llhp_pkg::P_OD_ESC, 6'd1);
            else want(llhp_pkg::P_CRC_FLAG, 6'd1);
         end
         llhp_pkg::P_CRC_FLAG: begin
            if (v[0]) want(llhp_pkg::P_CRC, 6'd8);
            else commit();
         end
         llhp_pkg::P_CRC: commit();
         llhp_pkg::P_PL_CHUNK: want(llhp_pkg::P_PL_STREAM, 6'd4);
         llhp_pkg::P_PL_STREAM: pl_stream();
         llhp_pkg::P_PL_BYTE: begin
            cslot_in = slot_sum[13] ? llhp_pkg::SLOT_MAX : slot_sum[12:0];
            if (v[7:0] == 8'd255) want(llhp_pkg::P_PL_BYTE, 6'd8);
            else if (!samefr_ff) want(llhp_pkg::P_PL_AUEND, 6'd1);
            else emit(llhp_pkg::ST_OK);
         end
         llhp_pkg::P_PL_CODED, llhp_pkg::P_PL_AUEND: emit(llhp_pkg::ST_OK);
         default: phase_in = llhp_pkg::P_DONE;
      endcase
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= llhp_pkg::P_IDLE;
         busy_ff <= 1'b0;
         ov_ff <= 1'b0;
         lastok_ff <= 1'b0;
         samefr_ff <= 1'b0;
         sv0_ff <= '0;
         sv1_ff <= '0;
         fill_ff <= '0;
         cap_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         busy_ff <= busy_in;
         ov_ff <= ov_in;
         lastok_ff <= lastok_in;
         samefr_ff <= samefr_in;
         sv0_ff <= sv0_in;
         sv1_ff <= sv1_in;
         fill_ff <= fill_in;
         cap_ff <= cap_in;
      end
      shift_ff <= shift_in; bcnt_ff <= bcnt_in; acc_ff <= acc_in; left_ff <= left_in;
      cver_ff <= cver_in; cfr_ff <= cfr_in; creu_ff <= creu_in; cgaext_ff <= cgaext_in;
      esc_ff <= esc_in; clen_ff <= clen_in; cslot_ff <= cslot_in; csub_ff <= csub_in;
      caot_ff <= caot_in; crate_ff <= crate_in; cchan_ff <= cchan_in; cflt_ff <= cflt_in;
      cfull_ff <= cfull_in; codl_ff <= codl_in; aword_ff <= aword_in;
      abits_ff <= abits_in; alen_ff <= alen_in; awbits_ff <= awbits_in;
      bleft_ff <= bleft_in; ost_ff <= ost_in; olen_ff <= olen_in; oslot_ff <= oslot_in;
      oreu_ff <= oreu_in; ow0_ff <= ow0_in; ow1_ff <= ow1_in;
   end

endmodule
